// ===== hw/rtl/sprf_pkg.sv =====
// Shared types, constants and the neighbor test of the isolated pixel filter.
`default_nettype none
package sprf_pkg;

	localparam int PIXEL_BITS      = 8;
	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int ROW_BITS        = 12;
	localparam int WIDTH_REG_BITS  = 12;
	localparam int HEIGHT_REG_BITS = 13;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 13;
	localparam int RES_MAX         = 3;
	localparam int COUNT_BITS      = 2;
	localparam int QUEUE_DEPTH     = 4;
	localparam int PTR_BITS        = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_BITS      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_LIMIT = HEIGHT_REG_BITS'(4096);
	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(2048);
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_LIMIT;

	typedef logic [PIXEL_BITS-1:0] pixel_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FILTER_THR   = 3'd0,
		REG_HORIZ_THR    = 3'd1,
		REG_VERT_THR     = 3'd2,
		REG_IMAGE_WIDTH  = 3'd3,
		REG_IMAGE_HEIGHT = 3'd4
	} sprf_reg_t;

	typedef struct packed {
		pixel_t filter;
		pixel_t horiz;
		pixel_t vert;
	} sprf_thr_t;

	typedef struct packed {
		pixel_t pixel_in;
	} sprf_in_t;

	typedef struct packed {
		pixel_t pixel_out;
		logic   last_of_run;
		logic   end_of_slice;
	} sprf_out_t;

	// results of one input word, packed in output order
	typedef struct packed {
		logic [COUNT_BITS-1:0]  count;
		logic                   eos;
		pixel_t [RES_MAX-1:0]   pix;
	} sprf_bundle_t;

	typedef struct packed {
		logic         valid;
		sprf_bundle_t bundle;
	} sprf_push_t;

	function automatic pixel_t judge(
		pixel_t c,
		pixel_t l, logic lv,
		pixel_t r, logic rv,
		pixel_t a, logic av,
		pixel_t b, logic bv,
		sprf_thr_t t
	);
		logic keep;
		keep = 1'b0;
		if (t.horiz != '0) begin
			keep = keep || (lv && (l >= t.horiz)) || (rv && (r >= t.horiz));
		end
		if (t.vert != '0) begin
			keep = keep || (av && (a >= t.vert)) || (bv && (b >= t.vert));
		end
		return ((c > t.filter) && keep) ? c : '0;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sprf_pixel_if.sv =====
// Input pixel channel: valid/ready handshake with one pixel word.
`default_nettype none
interface sprf_pixel_if;
	logic               valid;
	logic               ready;
	sprf_pkg::sprf_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sprf_result_if.sv =====
// Result channel: valid/ready handshake with one filtered pixel word.
`default_nettype none
interface sprf_result_if;
	logic                valid;
	logic                ready;
	sprf_pkg::sprf_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sprf_front.sv =====
// Front end: raster counters, line stores and neighbor tests, one pixel per clock while the queue has room.
`default_nettype none
module sprf_front #(
	parameter int MAX_WIDTH = sprf_pkg::MAX_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sprf_pkg::pixel_t                      pixel_in,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  sprf_pkg::sprf_thr_t                   thr,
	input  logic [sprf_pkg::WIDTH_REG_BITS-1:0]   image_width,
	input  logic [sprf_pkg::HEIGHT_REG_BITS-1:0]  image_height,
	input  logic [sprf_pkg::LEVEL_BITS-1:0]       level,
	output sprf_pkg::sprf_push_t                  push
);
	import sprf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = (AW + 1 > WIDTH_REG_BITS) ? AW + 1 : WIDTH_REG_BITS;
	localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

	logic [AW-1:0]              col_q;
	logic [ROW_BITS-1:0]        row_q;
	logic [CW-1:0]              img_w;
	logic [CW-1:0]              eff_w;
	logic [HEIGHT_REG_BITS-1:0] eff_h;
	logic                       row_end;
	logic                       last_row;
	logic                       accept;
	logic [AW-1:0]              rd_r_addr;

	pixel_t mid_mem   [MAX_WIDTH];
	pixel_t above_mem [MAX_WIDTH];

	logic          v_s1;
	pixel_t        cur_s1;
	logic [AW-1:0] x_s1;
	logic          has_l_s1, has_l2_s1, row_end_s1, last_row_s1, y1_s1, y2_s1;
	pixel_t        mid_c_s1, mid_r_s1, abv_mem_s1, fwd_s1;
	logic          byp_s1;

	pixel_t held_q, prv1_q, prv2_q;

	pixel_t                abv;
	pixel_t                res_a, res_b, res_c;
	logic                  emit_a, emit_b, emit_c;
	logic [COUNT_BITS-1:0] count;

	assign img_w = CW'(image_width);

	always_comb begin
		priority if (img_w == '0) eff_w = CW'(1);
		else if (img_w > MAXW)    eff_w = MAXW;
		else                      eff_w = img_w;
	end

	always_comb begin
		priority if (image_height == '0)   eff_h = HEIGHT_REG_BITS'(1);
		else if (image_height > HEIGHT_LIMIT) eff_h = HEIGHT_LIMIT;
		else                               eff_h = image_height;
	end

	assign row_end  = (CW'(col_q) + CW'(1)) >= eff_w;
	assign last_row = (HEIGHT_REG_BITS'(row_q) + HEIGHT_REG_BITS'(1)) >= eff_h;

	// room for the word in flight plus any already queued
	assign in_ready = (level + LEVEL_BITS'(v_s1)) < LEVEL_BITS'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	assign rd_r_addr = row_end ? col_q : col_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// middle row store: read-first, so the read at col_q sees the old row
	always_ff @(posedge clk) begin
		if (accept) begin
			mid_c_s1       <= mid_mem[col_q];
			mid_r_s1       <= mid_mem[rd_r_addr];
			mid_mem[col_q] <= pixel_in;
		end
	end

	// upper row store, written in the cycle after the middle row read, from that read
	always_ff @(posedge clk) begin
		if (accept) begin
			abv_mem_s1 <= above_mem[col_q];
		end
		if (v_s1) begin
			above_mem[x_s1] <= mid_c_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= pixel_in;
			x_s1        <= col_q;
			has_l_s1    <= col_q != '0;
			has_l2_s1   <= col_q > AW'(1);
			row_end_s1  <= row_end;
			last_row_s1 <= last_row;
			y1_s1       <= row_q != '0;
			y2_s1       <= row_q > ROW_BITS'(1);
			byp_s1      <= v_s1 && (x_s1 == col_q);
			fwd_s1      <= mid_c_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (v_s1) begin
			held_q <= mid_c_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prv1_q <= cur_s1;
			prv2_q <= prv1_q;
		end
	end

	assign abv = byp_s1 ? fwd_s1 : abv_mem_s1;

	always_comb begin
		// lagged pixel of the row above
		res_a = judge(mid_c_s1, held_q, has_l_s1, mid_r_s1, !row_end_s1,
			abv, y2_s1, cur_s1, 1'b1, thr);
		// previous pixel of the last row
		res_b = judge(prv1_q, prv2_q, has_l2_s1, cur_s1, 1'b1,
			held_q, y1_s1, '0, 1'b0, thr);
		// final pixel of the slice
		res_c = judge(cur_s1, prv1_q, has_l_s1, '0, 1'b0,
			mid_c_s1, y1_s1, '0, 1'b0, thr);
		emit_a = y1_s1;
		emit_b = last_row_s1 && has_l_s1;
		emit_c = last_row_s1 && row_end_s1;
		count  = COUNT_BITS'(emit_a) + COUNT_BITS'(emit_b) + COUNT_BITS'(emit_c);

		push.valid        = v_s1 && (count != '0);
		push.bundle.count = count;
		push.bundle.eos   = emit_c;
		push.bundle.pix[2] = res_c;
		push.bundle.pix[1] = (emit_a && emit_b) ? res_b : res_c;
		push.bundle.pix[0] = emit_a ? res_a : (emit_b ? res_b : res_c);
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sprf_queue.sv =====
// Short queue of result bundles between the front end and the output side.
`default_nettype none
module sprf_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sprf_pkg::sprf_push_t              push,
	input  logic                              pop,
	output sprf_pkg::sprf_bundle_t            head,
	output logic                              nonempty,
	output logic [sprf_pkg::LEVEL_BITS-1:0]   level
);
	import sprf_pkg::*;

	sprf_bundle_t        mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [LEVEL_BITS-1:0] level_q;

	assign head     = mem_q[rd_q];
	assign nonempty = level_q != '0;
	assign level    = level_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push.valid) wr_q <= wr_q + PTR_BITS'(1);
			if (pop)        rd_q <= rd_q + PTR_BITS'(1);
			unique case ({push.valid, pop})
				2'b10:   level_q <= level_q + LEVEL_BITS'(1);
				2'b01:   level_q <= level_q - LEVEL_BITS'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sprf_back.sv =====
// Output side: holds one bundle and sends its pixels one word at a time.
`default_nettype none
module sprf_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sprf_pkg::sprf_bundle_t  head,
	input  logic                    nonempty,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output sprf_pkg::sprf_out_t     out_word
);
	import sprf_pkg::*;

	sprf_bundle_t          bnd_q;
	logic                  valid_q;
	logic [COUNT_BITS-1:0] idx_q;
	logic                  last;
	logic                  take;

	assign last = idx_q == COUNT_BITS'(bnd_q.count - COUNT_BITS'(1));
	assign take = valid_q && out_ready;
	assign pop  = nonempty && (!valid_q || (take && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (last) valid_q <= 1'b0;
			else      idx_q   <= idx_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) bnd_q <= head;
	end

	assign out_valid             = valid_q;
	assign out_word.pixel_out    = bnd_q.pix[idx_q];
	assign out_word.last_of_run  = last;
	assign out_word.end_of_slice = last && bnd_q.eos;

endmodule
`default_nettype wire

// ===== hw/rtl/solitary_pixel_removal_filter.sv =====
// Top level of the isolated pixel removal filter: configuration and block wiring.
`default_nettype none
// Takes one 8-bit pixel per clock in raster order while the queue has room,
// and returns each pixel unchanged or as 0, one row late: the pixels of row
// y come out while row y+1 arrives, and the last row of a slice is emitted
// as it arrives, interleaved with the row above. Outside the last row the
// block takes a pixel every cycle while the result port keeps up; on the
// last row each pixel after the first yields two words (three at the end of
// the slice) and the single-word result port sets the pace, with a four-entry
// queue absorbing the bursts. A word passes the stage-1 registers, the queue
// and the output register before it is valid on the result port. Two line
// stores of MAX_WIDTH pixels hold the previous rows; they need no clearing
// after reset. Write configuration only while no results are pending.
module solitary_pixel_removal_filter #(
	parameter int MAX_WIDTH = sprf_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	sprf_pixel_if.sink                          pixel_stream,
	sprf_result_if.source                       result_stream,
	input  logic                                cfg_we,
	input  logic [sprf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sprf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import sprf_pkg::*;

	sprf_thr_t                  thr_q;
	logic [WIDTH_REG_BITS-1:0]  width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;

	sprf_push_t              push;
	sprf_bundle_t            head;
	logic                    nonempty;
	logic                    pop;
	logic [LEVEL_BITS-1:0]   level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= '0;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (sprf_reg_t'(cfg_index))
				REG_FILTER_THR:   thr_q.filter <= cfg_data[PIXEL_BITS-1:0];
				REG_HORIZ_THR:    thr_q.horiz  <= cfg_data[PIXEL_BITS-1:0];
				REG_VERT_THR:     thr_q.vert   <= cfg_data[PIXEL_BITS-1:0];
				REG_IMAGE_WIDTH:  width_q      <= cfg_data[WIDTH_REG_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q     <= cfg_data[HEIGHT_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	sprf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_in    (pixel_stream.data.pixel_in),
		.in_valid    (pixel_stream.valid),
		.in_ready    (pixel_stream.ready),
		.thr         (thr_q),
		.image_width (width_q),
		.image_height(height_q),
		.level       (level),
		.push        (push)
	);

	sprf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.head    (head),
		.nonempty(nonempty),
		.level   (level)
	);

	sprf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.out_valid(result_stream.valid),
		.out_ready(result_stream.ready),
		.out_word (result_stream.data)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/sprf_checker.sv =====
// Port-level checks of the isolated pixel removal filter, bound to the top level.
`default_nettype none
module sprf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input sprf_pkg::sprf_out_t out_word
);
	import sprf_pkg::*;

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seen_q <= 1'b0;
		else if (in_valid && in_ready) seen_q <= 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("result word before any pixel was taken");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.end_of_slice |-> out_word.last_of_run)
		else $error("end of slice not on the last word of a run");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output side is empty");

endmodule

bind solitary_pixel_removal_filter sprf_checker u_sprf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pixel_stream.valid),
	.in_ready (pixel_stream.ready),
	.out_valid(result_stream.valid),
	.out_ready(result_stream.ready),
	.out_word (result_stream.data)
);
`default_nettype wire

// ===== dv/tb_solitary_pixel_removal_filter.sv =====
// Self-checking testbench for the isolated pixel removal filter.
`timescale 1ns / 100ps
module tb_solitary_pixel_removal_filter;
	import sprf_pkg::*;

	localparam int MAXW          = MAX_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0]   cfg_data;

	sprf_pixel_if  pix_ch();
	sprf_result_if res_ch();

	solitary_pixel_removal_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_stream(pix_ch),
		.result_stream(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register shadow
	pixel_t                     filt_lvl, horiz_lvl, vert_lvl;
	logic [WIDTH_REG_BITS-1:0]  width_reg;
	logic [HEIGHT_REG_BITS-1:0] height_reg;

	// line stores and raster position of the predictor
	pixel_t      line_above [MAXW];
	pixel_t      line_mid [MAXW];
	int unsigned col_pos, row_pos;
	pixel_t      held_left;

	pixel_t      raw_pixels[$];
	sprf_out_t   filtered_due[$];
	sprf_out_t   due_word;
	int unsigned mismatch_cnt;
	int unsigned quiet_cycles;
	int unsigned send_gap_pct, recv_gap_pct;
	int unsigned stall_req, stall_seen, stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		mismatch_cnt++;
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	function automatic pixel_t screen(pixel_t c, pixel_t l, bit lv, pixel_t r, bit rv,
			pixel_t a, bit av, pixel_t b, bit bv);
		bit side_ok, vert_ok;
		side_ok = (horiz_lvl != 0) && ((lv && l >= horiz_lvl) || (rv && r >= horiz_lvl));
		vert_ok = (vert_lvl != 0) && ((av && a >= vert_lvl) || (bv && b >= vert_lvl));
		return (c > filt_lvl && (side_ok || vert_ok)) ? c : 8'd0;
	endfunction

	function automatic void filter_pixel(pixel_t cur);
		int unsigned w, h, x, y, n;
		bit          row_end, last_row;
		pixel_t      mid_x, right_px;
		sprf_out_t   outs [RES_MAX];
		w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
		x = col_pos;
		y = row_pos;
		row_end = (x + 1 >= w);
		last_row = (y + 1 >= h);
		n = 0;
		mid_x = line_mid[x];
		right_px = row_end ? 8'd0 : line_mid[x + 1];
		// lagged pixel of the row above
		if (y >= 1) begin
			outs[n] = '{screen(mid_x, held_left, x > 0, right_px, !row_end,
				line_above[x], y >= 2, cur, 1'b1), 1'b0, 1'b0};
			n++;
		end
		held_left = mid_x;
		line_above[x] = mid_x;
		line_mid[x] = cur;
		if (last_row && x >= 1) begin
			outs[n] = '{screen(line_mid[x - 1], (x >= 2) ? line_mid[x - 2] : 8'd0, x >= 2,
				cur, 1'b1, line_above[x - 1], y >= 1, 8'd0, 1'b0), 1'b0, 1'b0};
			n++;
		end
		if (last_row && row_end) begin
			outs[n] = '{screen(cur, (x >= 1) ? line_mid[x - 1] : 8'd0, x >= 1, 8'd0, 1'b0,
				line_above[x], y >= 1, 8'd0, 1'b0), 1'b0, 1'b1};
			n++;
		end
		if (n > 0)
			outs[n - 1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			filtered_due.push_back(outs[i]);
		if (row_end) begin
			col_pos = 0;
			row_pos = last_row ? 0 : ((y + 1) & 12'hFFF);
		end else begin
			col_pos = (x + 1) & 11'h7FF;
		end
	endfunction

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			pix_ch.data <= '0;
		end else if (!pix_ch.valid || pix_ch.ready) begin
			if (raw_pixels.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				pix_ch.valid <= 1'b1;
				pix_ch.data.pixel_in <= raw_pixels.pop_front();
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// result sink with random stalls and a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_seen <= 0;
			stall_left <= 0;
		end else if (stall_seen != stall_req) begin
			stall_seen <= stall_req;
			stall_left <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready)
				filter_pixel(pix_ch.data.pixel_in);
			if (res_ch.valid && res_ch.ready) begin
				if (filtered_due.size() == 0) begin
					report_mismatch("word with nothing due", 0, res_ch.data.pixel_out);
				end else begin
					due_word = filtered_due.pop_front();
					if (res_ch.data.pixel_out !== due_word.pixel_out)
						report_mismatch("pixel_out", due_word.pixel_out, res_ch.data.pixel_out);
					if (res_ch.data.last_of_run !== due_word.last_of_run)
						report_mismatch("last_of_run", due_word.last_of_run,
							res_ch.data.last_of_run);
					if (res_ch.data.end_of_slice !== due_word.end_of_slice)
						report_mismatch("end_of_slice", due_word.end_of_slice,
							res_ch.data.end_of_slice);
				end
			end
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(sprf_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FILTER_THR:   filt_lvl = val[7:0];
			REG_HORIZ_THR:    horiz_lvl = val[7:0];
			REG_VERT_THR:     vert_lvl = val[7:0];
			REG_IMAGE_WIDTH:  width_reg = val[WIDTH_REG_BITS-1:0];
			REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_REG_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_filter(int unsigned f, int unsigned hz, int unsigned v,
			int unsigned w, int unsigned h);
		write_reg(REG_FILTER_THR, CFG_DATA_BITS'(f));
		write_reg(REG_HORIZ_THR, CFG_DATA_BITS'(hz));
		write_reg(REG_VERT_THR, CFG_DATA_BITS'(v));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (raw_pixels.size() != 0 || pix_ch.valid || filtered_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_gaps(int unsigned send_pct, int unsigned recv_pct);
		@(negedge clk);
		send_gap_pct = send_pct;
		recv_gap_pct = recv_pct;
	endtask

	task automatic push_pixels(pixel_t vals[$]);
		@(negedge clk);
		foreach (vals[i])
			raw_pixels.push_back(vals[i]);
	endtask

	function automatic pixel_t rand_pixel();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return pixel_t'($urandom_range(0, 255));
			2: return pixel_t'($urandom_range(200, 255));
			default: return pixel_t'($urandom_range(1, 80));
		endcase
	endfunction

	function automatic int unsigned rand_level();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
	endfunction

	task automatic feed_random(int unsigned count);
		@(negedge clk);
		repeat (count) raw_pixels.push_back(rand_pixel());
	endtask

	task automatic random_slices(int unsigned budget);
		int unsigned w, h, done;
		done = 0;
		while (done < budget) begin
			w = $urandom_range(0, 8);
			h = $urandom_range(0, 6);
			wait_idle();
			set_filter(rand_level(), rand_level(), rand_level(), w, h);
			feed_random(((w == 0) ? 1 : w) * ((h == 0) ? 1 : h));
			done += ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FILTER_THR;
		cfg_data = '0;
		filt_lvl = '0;
		horiz_lvl = '0;
		vert_lvl = '0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		col_pos = 0;
		row_pos = 0;
		held_left = '0;
		mismatch_cnt = 0;
		quiet_cycles = 0;
		stall_req = 0;
		send_gap_pct = 12;
		recv_gap_pct = 75;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: 4x3 slice with both neighbor directions live
		set_filter(100, 50, 50, 4, 3);
		push_pixels({8'd255, 8'd0, 8'd200, 8'd101,
			8'd0, 8'd255, 8'd100, 8'd50,
			8'd255, 8'd49, 8'd255, 8'd0});
		// single-row slice, horizontal checks off
		wait_idle();
		set_filter(0, 0, 1, 3, 1);
		push_pixels({8'd255, 8'd1, 8'd255});
		// thresholds at the top
		wait_idle();
		set_filter(255, 255, 255, 2, 2);
		push_pixels({8'd255, 8'd255, 8'd255, 8'd255});
		// zero sizes act as 1x1
		wait_idle();
		set_filter(0, 255, 0, 0, 0);
		push_pixels({8'd255, 8'd128});

		random_slices(25);

		set_gaps(75, 12);
		random_slices(25);
		// shrink width and height in the middle of a slice
		wait_idle();
		set_filter(20, 60, 60, 6, 6);
		feed_random(20);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(2));
		feed_random(7);

		set_gaps(0, 0);
		// long hold-off on results while pixels keep coming
		wait_idle();
		set_filter(10, 30, 30, 8, 4);
		@(negedge clk);
		stall_req++;
		feed_random(32);
		// width above the store size, closed by a shrink
		wait_idle();
		set_filter(rand_level(), rand_level(), rand_level(), 4095, 1);
		feed_random(20);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(21));
		feed_random(1);
		// height above the limit, closed by a shrink
		wait_idle();
		set_filter(rand_level(), rand_level(), rand_level(), 1, 8191);
		feed_random(6);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(7));
		feed_random(1);

		wait_idle();
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
